### rtl/ack_pkg.sv
// ----------------------------------------------------------------------------
// ack_pkg: shared types and constants for the covariance kernel
// Fixed-point formats, kernel codes, register indexes, pipeline depths.
// ----------------------------------------------------------------------------
`default_nettype none

package ack_pkg;

    // field widths
    localparam int COORD_W  = 24;
    localparam int SCALE_W  = 24;
    localparam int VALUE_W  = 17;
    localparam int ABS_W    = 24;
    localparam int ARG_W    = 22;
    localparam int TERM_W   = 40;
    localparam int POLY_W   = 28;
    localparam int EXP_W    = 32;
    localparam int SHIFT_W  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int DIMS_W   = 3;
    localparam int KTYPE_W  = 2;
    localparam int NUM_COORDS   = 4;
    localparam int DEF_MAX_DIMS = 4;

    // pipeline depths
    localparam int EXP_TERMS = 7;
    localparam int EXP_LAT   = 2 * EXP_TERMS + 3;
    localparam int LANE_LAT  = EXP_LAT + 5;

    // fixed-point constants
    localparam logic [16:0] ONE_Q16         = 17'd65536;
    localparam logic [30:0] ONE_Q30         = 31'd1073741824;
    localparam logic [15:0] LN2_Q16         = 16'd45426;
    localparam logic [14:0] LN2_RECIP_Q30   = 15'd23637;
    localparam logic [17:0] SQRT3_Q16       = 18'd113512;
    localparam logic [17:0] SQRT5_Q16       = 18'd146543;
    localparam logic [16:0] FIVE_THIRDS_Q16 = 17'd109227;
    localparam logic [21:0] ARG_LIMIT       = 22'd2097152;
    localparam logic [29:0] HALF_Q30        = 30'd536870912;
    localparam logic [15:0] HALF_Q16        = 16'd32768;
    localparam logic [13:0] HALF_Q14        = 14'd8192;

    // floor(2^32 / k) for the series divisions
    localparam logic [32:0] RECIP_Q32 [1:EXP_TERMS] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756
    };

    // kernel codes
    typedef enum logic [KTYPE_W-1:0] {
        KT_GAUSS    = 2'd0,
        KT_MATERN32 = 2'd1,
        KT_MATERN52 = 2'd2
    } kernel_type_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_3 = 3'd5;

    // pipeline control shared by lanes and merge
    typedef struct packed {
        logic en;
        logic matern;
        logic five;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

### rtl/ack_exp.sv
// ----------------------------------------------------------------------------
// ack_exp: pipelined exp(-x) in Q.30 for x in Q.16
// Range reduction by ln2, seven-term series, one stage pair per term.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_exp
    import ack_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [ARG_W-1:0] x,
    output logic      [EXP_W-1:0] e
);

    // stage 1: quotient estimate by reciprocal
    logic [36:0]        q_full;
    logic [ARG_W-1:0]   x1_reg;
    logic [SHIFT_W-1:0] q1_reg;
    logic               zero1_reg;

    assign q_full = 37'(x) * 37'(LN2_RECIP_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= x;
            q1_reg    <= q_full[35:30];
            zero1_reg <= (x >= ARG_LIMIT);
        end
    end

    // stage 2: remainder with one correction step
    logic [ARG_W-1:0]   r_raw;
    logic               r_over;
    logic [ARG_W-1:0]   r_fix;

    assign r_raw  = x1_reg - ARG_W'(22'(q1_reg) * 22'(LN2_Q16));
    assign r_over = (r_raw >= 22'(LN2_Q16));
    assign r_fix  = r_over ? (r_raw - 22'(LN2_Q16)) : r_raw;

    logic [30:0]        term_reg [0:EXP_TERMS];
    logic [31:0]        pos_reg  [0:EXP_TERMS];
    logic [31:0]        neg_reg  [0:EXP_TERMS];
    logic [29:0]        r30_reg  [0:EXP_TERMS];
    logic [SHIFT_W-1:0] n_reg    [0:EXP_TERMS];
    logic               zero_reg [0:EXP_TERMS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg[0] <= ONE_Q30;
            pos_reg[0]  <= 32'(ONE_Q30);
            neg_reg[0]  <= '0;
            r30_reg[0]  <= {r_fix[15:0], 14'd0};
            n_reg[0]    <= q1_reg + SHIFT_W'(r_over);
            zero_reg[0] <= zero1_reg;
        end
    end

    // series terms: multiply stage, then divide-by-k stage
    logic [30:0]        va_reg   [1:EXP_TERMS];
    logic [31:0]        posa_reg [1:EXP_TERMS];
    logic [31:0]        nega_reg [1:EXP_TERMS];
    logic [29:0]        r30a_reg [1:EXP_TERMS];
    logic [SHIFT_W-1:0] na_reg   [1:EXP_TERMS];
    logic               zeroa_reg[1:EXP_TERMS];

    for (genvar k = 1; k <= EXP_TERMS; k++)
    begin : g_term
        localparam logic [31:0] KDIV = 32'(k);

        logic [60:0] m_full;
        logic [63:0] rq_full;
        logic [31:0] q0;
        logic [31:0] rem;
        logic [31:0] q;

        assign m_full  = 61'(term_reg[k-1]) * 61'(r30_reg[k-1]);
        assign rq_full = 64'(va_reg[k]) * 64'(RECIP_Q32[k]);
        assign q0      = rq_full[63:32];
        assign rem     = 32'(va_reg[k]) - (q0 * KDIV);
        assign q       = (rem >= KDIV) ? (q0 + 32'd1) : q0;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                va_reg[k]    <= m_full[60:30];
                posa_reg[k]  <= pos_reg[k-1];
                nega_reg[k]  <= neg_reg[k-1];
                r30a_reg[k]  <= r30_reg[k-1];
                na_reg[k]    <= n_reg[k-1];
                zeroa_reg[k] <= zero_reg[k-1];

                term_reg[k] <= q[30:0];
                r30_reg[k]  <= r30a_reg[k];
                n_reg[k]    <= na_reg[k];
                zero_reg[k] <= zeroa_reg[k];
                if (k % 2 == 1)
                begin
                    pos_reg[k] <= posa_reg[k];
                    neg_reg[k] <= nega_reg[k] + q;
                end
                else
                begin
                    pos_reg[k] <= posa_reg[k] + q;
                    neg_reg[k] <= nega_reg[k];
                end
            end
        end
    end

    // final: alternating sum, floored, scaled by 2^-n
    logic [31:0] v;

    assign v = (pos_reg[EXP_TERMS] > neg_reg[EXP_TERMS])
             ? (pos_reg[EXP_TERMS] - neg_reg[EXP_TERMS]) : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e <= zero_reg[EXP_TERMS] ? '0 : (v >> n_reg[EXP_TERMS]);
        end
    end

endmodule

`default_nettype wire

### rtl/ack_lane.sv
// ----------------------------------------------------------------------------
// ack_lane: per-dimension datapath
// Gaussian term diff^2*inv and Matern factor poly(d)*exp(-c*d) for one axis.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_lane
    import ack_pkg::*;
(
    input  wire logic                       clk,
    input  wire pipe_ctrl_t                 ctrl,
    input  wire logic                       active,
    input  wire logic signed [COORD_W-1:0]  a_coord,
    input  wire logic signed [COORD_W-1:0]  b_coord,
    input  wire logic        [SCALE_W-1:0]  inv_scale,
    output logic             [TERM_W-1:0]   term,
    output logic             [VALUE_W-1:0]  factor
);

    // stage 1: absolute difference
    logic signed [COORD_W:0] diff;
    logic        [COORD_W:0] mag;
    logic [ABS_W-1:0]        ad_reg;
    logic                    act1_reg;

    assign diff = {a_coord[COORD_W-1], a_coord} - {b_coord[COORD_W-1], b_coord};
    assign mag  = diff[COORD_W] ? (-diff) : diff;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            ad_reg   <= mag[ABS_W-1:0];
            act1_reg <= active;
        end
    end

    // stage 2: square and scaled distance
    logic [47:0] sq_full;
    logic [47:0] d_full;
    logic [31:0] sq_reg;
    logic [31:0] d_reg;
    logic        act2_reg;

    assign sq_full = 48'(ad_reg) * 48'(ad_reg);
    assign d_full  = 48'(ad_reg) * 48'(inv_scale);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            sq_reg   <= sq_full[47:16];
            d_reg    <= d_full[47:16];
            act2_reg <= act1_reg;
        end
    end

    // stage 3: gaussian term, exp argument, d squared
    logic [55:0] term_full;
    logic [17:0] c_sel;
    logic [49:0] t_full;
    logic [33:0] t_wide;
    logic [41:0] dd_full;
    logic [TERM_W-1:0] term_reg;
    logic [ARG_W-1:0] t_reg;
    logic [25:0] dd_reg;

    assign term_full = 56'(sq_reg) * 56'(inv_scale);
    assign c_sel     = ctrl.five ? SQRT5_Q16 : SQRT3_Q16;
    assign t_full    = 50'(d_reg) * 50'(c_sel);
    assign t_wide    = t_full[49:16];
    assign dd_full   = 42'(d_reg[20:0]) * 42'(d_reg[20:0]);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            term_reg <= act2_reg ? term_full[55:16] : '0;
            if (!act2_reg)
                t_reg <= '0;
            else if (t_wide >= 34'(ARG_LIMIT))
                t_reg <= ARG_LIMIT;
            else
                t_reg <= t_wide[ARG_W-1:0];
            dd_reg <= act2_reg ? dd_full[41:16] : '0;
        end
    end

    assign term = term_reg;

    // stage 4: polynomial factor
    logic [42:0]       p2_full;
    logic [POLY_W-1:0] p2;
    logic [POLY_W-1:0] poly_reg;
    logic [ARG_W-1:0]  x_reg;

    assign p2_full = 43'(dd_reg) * 43'(FIVE_THIRDS_Q16);
    assign p2      = ctrl.five ? POLY_W'(p2_full[42:16]) : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            poly_reg <= POLY_W'(ONE_Q16) + POLY_W'(t_reg) + p2;
            x_reg    <= t_reg;
        end
    end

    // exponential and matching delay for the polynomial
    logic [EXP_W-1:0]  e;
    logic [POLY_W-1:0] poly_dly_reg [EXP_LAT];

    ack_exp u_exp (
        .clk (clk),
        .en  (ctrl.en),
        .x   (x_reg),
        .e   (e)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            poly_dly_reg[0] <= poly_reg;
            for (int i = 1; i < EXP_LAT; i++)
                poly_dly_reg[i] <= poly_dly_reg[i-1];
        end
    end

    // factor with rounding, saturated at one
    logic [59:0] f_full;
    logic [29:0] f_shift;

    assign f_full  = 60'(poly_dly_reg[EXP_LAT-1]) * 60'(e) + 60'(HALF_Q30);
    assign f_shift = f_full[59:30];

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            factor <= (f_shift > 30'(ONE_Q16)) ? ONE_Q16 : f_shift[VALUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/ack_merge.sv
// ----------------------------------------------------------------------------
// ack_merge: combines the lane results
// Gaussian: saturated sum then exp. Matern: rounded product chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_merge
    import ack_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS
)
(
    input  wire logic                clk,
    input  wire pipe_ctrl_t          ctrl,
    input  wire logic [TERM_W-1:0]   term   [MAX_DIMS],
    input  wire logic [VALUE_W-1:0]  factor [MAX_DIMS],
    output logic      [VALUE_W-1:0]  kernel_value
);

    // gaussian argument: sum of terms, saturated
    logic [TERM_W+1:0] sum;
    logic [ARG_W-1:0]  x_reg;

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < MAX_DIMS; k++)
            sum = sum + (TERM_W+2)'(term[k]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            x_reg <= (sum >= (TERM_W+2)'(ARG_LIMIT)) ? ARG_LIMIT : sum[ARG_W-1:0];
        end
    end

    logic [EXP_W-1:0] e;

    ack_exp u_exp (
        .clk (clk),
        .en  (ctrl.en),
        .x   (x_reg),
        .e   (e)
    );

    // round Q.30 to Q.16, saturate
    logic [EXP_W:0]   g_full;
    logic [18:0]      g_shift;
    logic [VALUE_W-1:0] g_reg;

    assign g_full  = (EXP_W+1)'(e) + (EXP_W+1)'(HALF_Q14);
    assign g_shift = g_full[EXP_W:14];

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            g_reg <= (g_shift > 19'(ONE_Q16)) ? ONE_Q16 : g_shift[VALUE_W-1:0];
        end
    end

    // product chain, one dimension per stage
    logic [VALUE_W-1:0] prod_reg [MAX_DIMS];
    logic [VALUE_W-1:0] gd_reg   [MAX_DIMS];
    logic [VALUE_W-1:0] fac_reg  [MAX_DIMS][MAX_DIMS];

    for (genvar j = 0; j < MAX_DIMS; j++)
    begin : g_chain
        logic [VALUE_W-1:0] prod_in;
        logic [VALUE_W-1:0] f_in;
        logic [33:0]        p_full;

        if (j == 0)
        begin : g_first
            assign prod_in = ONE_Q16;
            assign f_in    = factor[0];
        end
        else
        begin : g_next
            assign prod_in = prod_reg[j-1];
            assign f_in    = fac_reg[j-1][j];
        end

        assign p_full = 34'(prod_in) * 34'(f_in) + 34'(HALF_Q16);

        always_ff @(posedge clk)
        begin
            if (ctrl.en)
            begin
                prod_reg[j] <= p_full[32:16];
                gd_reg[j]   <= (j == 0) ? g_reg : gd_reg[(j == 0) ? 0 : j-1];
                for (int k = 0; k < MAX_DIMS; k++)
                    fac_reg[j][k] <= (j == 0) ? factor[k] : fac_reg[(j == 0) ? 0 : j-1][k];
            end
        end
    end

    assign kernel_value = ctrl.matern ? prod_reg[MAX_DIMS-1] : gd_reg[MAX_DIMS-1];

endmodule

`default_nettype wire

### rtl/anisotropic_covariance_kernel_top.sv
// ----------------------------------------------------------------------------
// anisotropic_covariance_kernel_top: Gaussian / Matern covariance of two points
// Per-axis lanes, merge; fully pipelined, one pair per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block takes one point pair on every cycle without a stall and returns its
// covariance at the end of the merge stage. Each axis has its own lane with a
// pipelined exp unit, and the merge stage has one more exp unit for the Gaussian
// sum plus a product chain of one stage per axis, which sets the depth. A stall
// on the result side freezes the whole pipeline, so req_stall follows
// rsp_valid && rsp_stall. Register writes are taken at once (cfg_ready is always
// high) and must be made only while no request is in flight.
`default_nettype none

module anisotropic_covariance_kernel_top
    import ack_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [SCALE_W-1:0]         cfg_data,

    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic signed [COORD_W-1:0]  a_coord_0,
    input  wire logic signed [COORD_W-1:0]  a_coord_1,
    input  wire logic signed [COORD_W-1:0]  a_coord_2,
    input  wire logic signed [COORD_W-1:0]  a_coord_3,
    input  wire logic signed [COORD_W-1:0]  b_coord_0,
    input  wire logic signed [COORD_W-1:0]  b_coord_1,
    input  wire logic signed [COORD_W-1:0]  b_coord_2,
    input  wire logic signed [COORD_W-1:0]  b_coord_3,

    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic [VALUE_W-1:0]              kernel_value
);

    localparam int TOTAL_LAT = LANE_LAT + MAX_DIMS;

    // configuration registers
    logic [KTYPE_W-1:0] kernel_type_reg;
    logic [DIMS_W-1:0]  dims_in_use_reg;
    logic [SCALE_W-1:0] inv_scale_reg [NUM_COORDS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_type_reg <= KT_GAUSS;
            dims_in_use_reg <= DIMS_W'(NUM_COORDS);
            for (int i = 0; i < NUM_COORDS; i++)
                inv_scale_reg[i] <= SCALE_W'(ONE_Q16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KERNEL_TYPE: kernel_type_reg  <= cfg_data[KTYPE_W-1:0];
                REG_DIMS_IN_USE: dims_in_use_reg  <= cfg_data[DIMS_W-1:0];
                REG_INV_SCALE_0: inv_scale_reg[0] <= cfg_data;
                REG_INV_SCALE_1: inv_scale_reg[1] <= cfg_data;
                REG_INV_SCALE_2: inv_scale_reg[2] <= cfg_data;
                REG_INV_SCALE_3: inv_scale_reg[3] <= cfg_data;
                default:         ;
            endcase
        end
    end

    // pipeline control
    pipe_ctrl_t ctrl;
    logic       en;

    assign en          = !(rsp_valid && rsp_stall);
    assign ctrl.en     = en;
    assign ctrl.matern = (kernel_type_reg == KT_MATERN32) || (kernel_type_reg == KT_MATERN52);
    assign ctrl.five   = (kernel_type_reg == KT_MATERN52);
    assign req_stall   = !en;

    // request valid travels alongside the data
    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] vld_next;

    assign vld_next = {vld_reg[TOTAL_LAT-2:0], req_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    assign rsp_valid = vld_reg[TOTAL_LAT-1];

    // per-axis lanes
    logic signed [COORD_W-1:0] a_arr [NUM_COORDS];
    logic signed [COORD_W-1:0] b_arr [NUM_COORDS];
    logic [TERM_W-1:0]         term   [MAX_DIMS];
    logic [VALUE_W-1:0]        factor [MAX_DIMS];

    assign a_arr[0] = a_coord_0;
    assign a_arr[1] = a_coord_1;
    assign a_arr[2] = a_coord_2;
    assign a_arr[3] = a_coord_3;
    assign b_arr[0] = b_coord_0;
    assign b_arr[1] = b_coord_1;
    assign b_arr[2] = b_coord_2;
    assign b_arr[3] = b_coord_3;

    for (genvar k = 0; k < MAX_DIMS; k++)
    begin : g_lane
        ack_lane u_lane (
            .clk       (clk),
            .ctrl      (ctrl),
            .active    (DIMS_W'(k) < dims_in_use_reg),
            .a_coord   (a_arr[k]),
            .b_coord   (b_arr[k]),
            .inv_scale (inv_scale_reg[k]),
            .term      (term[k]),
            .factor    (factor[k])
        );
    end

    // merge
    ack_merge #(
        .MAX_DIMS (MAX_DIMS)
    ) u_merge (
        .clk          (clk),
        .ctrl         (ctrl),
        .term         (term),
        .factor       (factor),
        .kernel_value (kernel_value)
    );

endmodule

`default_nettype wire

### rtl/ack_chk.sv
// ----------------------------------------------------------------------------
// ack_chk: port-level checks for the covariance kernel
// Watches the handshakes and the result range; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_chk
    import ack_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_stall,
    input wire logic               rsp_valid,
    input wire logic               rsp_stall,
    input wire logic [VALUE_W-1:0] kernel_value
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(kernel_value))
        else $error("result changed while stalled");

    // request side stalls only when the result side is blocked
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("request stall not tied to result stall");

    // covariance never exceeds one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> kernel_value <= ONE_Q16)
        else $error("kernel value above one");

    // the request side is never stalled while the result stage is empty
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with empty result stage");

    // a stalled request stays offered
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid)
        else $error("stalled request withdrawn");

endmodule

bind anisotropic_covariance_kernel_top ack_chk u_ack_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .kernel_value (kernel_value)
);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: covariance kernel bench
// Drives point pairs through the Gaussian and Matern kernel modes under a
// series of register settings, with random request idle and result stall, and
// checks every kernel value against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
    import ack_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 190;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCALE_W-1:0] cfg_data;
    logic req_valid;
    logic req_stall;
    logic rsp_valid;
    logic rsp_stall;
    logic [VALUE_W-1:0] kernel_value;
    logic [COORD_W-1:0] pa [NUM_COORDS];
    logic [COORD_W-1:0] pb [NUM_COORDS];

    // register copies used by the predictor
    logic [KTYPE_W-1:0] cur_kernel;
    logic [DIMS_W-1:0] cur_dims;
    logic [SCALE_W-1:0] cur_scale [NUM_COORDS];

    logic [VALUE_W-1:0] pending_values [$];
    int fail_count;
    int quiet_cycles;
    logic idle_on;

    typedef struct {
        logic [KTYPE_W-1:0] kt;
        logic [DIMS_W-1:0] dims;
        logic [SCALE_W-1:0] scale0;
        logic [COORD_W-1:0] a [NUM_COORDS];
        logic [COORD_W-1:0] b [NUM_COORDS];
        bit chk;
        logic [VALUE_W-1:0] val;
    } pair_row_t;

    anisotropic_covariance_kernel_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_stall(req_stall),
        .a_coord_0(pa[0]), .a_coord_1(pa[1]), .a_coord_2(pa[2]), .a_coord_3(pa[3]),
        .b_coord_0(pb[0]), .b_coord_1(pb[1]), .b_coord_2(pb[2]), .b_coord_3(pb[3]),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .kernel_value(kernel_value)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // exp(-x) in Q.30 by range reduction and a short series
    function automatic longint unsigned exp_neg_q30(longint unsigned x);
        longint unsigned n, r30, term, pos, neg;
        if (x >= longint'(ARG_LIMIT))
            return 0;
        n = x / LN2_Q16;
        r30 = (x - n * LN2_Q16) << 14;
        term = ONE_Q30;
        pos = ONE_Q30;
        neg = 0;
        for (int k = 1; k <= EXP_TERMS; k++)
        begin
            term = ((term * r30) >> 30) / k;
            if (k % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        return ((pos > neg) ? pos - neg : 0) >> n;
    endfunction

    // one axis factor of the Matern product
    function automatic longint unsigned matern_axis(longint unsigned d, bit five);
        longint unsigned t, poly, f;
        t = (d * (five ? SQRT5_Q16 : SQRT3_Q16)) >> 16;
        if (t >= longint'(ARG_LIMIT))
            return 0;
        poly = ONE_Q16 + t;
        if (five)
            poly += (((d * d) >> 16) * FIVE_THIRDS_Q16) >> 16;
        f = (poly * exp_neg_q30(t) + HALF_Q30) >> 30;
        return (f > ONE_Q16) ? ONE_Q16 : f;
    endfunction

    // covariance of a pair under the current registers
    function automatic logic [VALUE_W-1:0] covariance(
        logic [COORD_W-1:0] a [NUM_COORDS], logic [COORD_W-1:0] b [NUM_COORDS]);
        longint unsigned x, prod, ad, res;
        longint diff;
        bit matern, five;
        matern = (cur_kernel == KT_MATERN32) || (cur_kernel == KT_MATERN52);
        five = (cur_kernel == KT_MATERN52);
        x = 0;
        prod = ONE_Q16;
        for (int k = 0; k < NUM_COORDS; k++)
        begin
            if (k < cur_dims)
            begin
                diff = longint'(signed'(a[k])) - longint'(signed'(b[k]));
                ad = (diff < 0) ? -diff : diff;
                if (matern)
                    prod = (prod * matern_axis((ad * cur_scale[k]) >> 16, five)
                            + HALF_Q16) >> 16;
                else
                begin
                    x += ((((ad * ad) >> 16)) * cur_scale[k]) >> 16;
                    if (x > ARG_LIMIT)
                        x = ARG_LIMIT;
                end
            end
        end
        res = matern ? prod : (exp_neg_q30(x) + HALF_Q14) >> 14;
        if (res > ONE_Q16)
            res = ONE_Q16;
        return res[VALUE_W-1:0];
    endfunction

    // result check and request capture
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_values.size() == 0)
            begin
                $error("kernel_value: unexpected result %0d", kernel_value);
                fail_count++;
            end
            else
            begin
                if (kernel_value !== pending_values[0])
                begin
                    $error("kernel_value: expected %0d actual %0d",
                           pending_values[0], kernel_value);
                    fail_count++;
                end
                void'(pending_values.pop_front());
            end
        end
        if (rst_n && req_valid && !req_stall)
            pending_values.insert(pending_values.size(), covariance(pa, pb));
    end

    // result side stall
    always @(negedge clk)
    begin
        rsp_stall <= idle_on && ($urandom_range(99) < 7);
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_KERNEL_TYPE: cur_kernel = data[KTYPE_W-1:0];
            REG_DIMS_IN_USE: cur_dims = data[DIMS_W-1:0];
            REG_INV_SCALE_0: cur_scale[0] = data;
            REG_INV_SCALE_1: cur_scale[1] = data;
            REG_INV_SCALE_2: cur_scale[2] = data;
            REG_INV_SCALE_3: cur_scale[3] = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_pair(logic [COORD_W-1:0] a [NUM_COORDS],
                             logic [COORD_W-1:0] b [NUM_COORDS]);
        if (idle_on && ($urandom_range(99) < 7))
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 4))
                @(negedge clk);
        end
        req_valid = 1'b1;
        pa = a;
        pb = b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid = 1'b0;
        while (pending_values.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    function automatic logic [SCALE_W-1:0] pick_scale(int mode);
        case (mode)
            0: return 24'hFFFFFF;
            1: return 24'd1;
            default:
            begin
                case ($urandom_range(9))
                    0: return 24'd0;
                    1: return SCALE_W'($urandom());
                    2: return 24'hFFFFFF;
                    default: return SCALE_W'($urandom_range(2048, 262144));
                endcase
            end
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        return COORD_W'($urandom());
    endfunction

    pair_row_t rows [$];
    pair_row_t row;
    logic [COORD_W-1:0] ra [NUM_COORDS];
    logic [COORD_W-1:0] rb [NUM_COORDS];
    logic [COORD_W-1:0] zeros [NUM_COORDS];
    logic [COORD_W-1:0] maxs [NUM_COORDS];
    logic [COORD_W-1:0] mins [NUM_COORDS];
    logic [COORD_W-1:0] unit [NUM_COORDS];
    logic [COORD_W-1:0] edge0 [NUM_COORDS];
    logic [COORD_W-1:0] edge1 [NUM_COORDS];
    logic [KTYPE_W-1:0] rk;
    logic [DIMS_W-1:0] rd;
    int span;

    task automatic add_row(int kt, int dims, int s0, logic [COORD_W-1:0] a [NUM_COORDS],
                           logic [COORD_W-1:0] b [NUM_COORDS], int chk, int val);
        pair_row_t r;
        r.kt = KTYPE_W'(kt);
        r.dims = DIMS_W'(dims);
        r.scale0 = SCALE_W'(s0);
        r.a = a;
        r.b = b;
        r.chk = (chk != 0);
        r.val = VALUE_W'(val);
        rows.insert(rows.size(), r);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 1'b0;
        rsp_stall = 1'b0;
        idle_on = 1'b1;
        fail_count = 0;
        quiet_cycles = 0;
        cur_kernel = KT_GAUSS;
        cur_dims = 3'd4;
        for (int k = 0; k < NUM_COORDS; k++)
        begin
            pa[k] = '0;
            pb[k] = '0;
            cur_scale[k] = SCALE_W'(ONE_Q16);
            zeros[k] = '0;
            maxs[k] = 24'h7FFFFF;
            mins[k] = 24'h800000;
            unit[k] = 24'h010000;
            edge0[k] = '0;
            edge1[k] = '0;
        end
        edge0[0] = 24'h7FFFFF;
        edge1[0] = 24'h800000;

        // directed table: typed values where the math is plain
        add_row(KT_GAUSS, 4, ONE_Q16, zeros, zeros, 1, ONE_Q16);
        add_row(KT_GAUSS, 4, ONE_Q16, maxs, mins, 1, 0);
        add_row(KT_GAUSS, 4, ONE_Q16, maxs, maxs, 1, ONE_Q16);
        add_row(KT_GAUSS, 4, ONE_Q16, mins, maxs, 1, 0);
        add_row(KT_GAUSS, 4, ONE_Q16, unit, zeros, 0, 0);
        add_row(KT_MATERN32, 4, ONE_Q16, zeros, zeros, 1, ONE_Q16);
        add_row(KT_MATERN32, 4, ONE_Q16, maxs, mins, 1, 0);
        add_row(KT_MATERN32, 4, ONE_Q16, unit, zeros, 0, 0);
        add_row(KT_MATERN52, 4, ONE_Q16, zeros, zeros, 1, ONE_Q16);
        add_row(KT_MATERN52, 4, ONE_Q16, maxs, mins, 1, 0);
        add_row(KT_MATERN52, 4, ONE_Q16, zeros, unit, 0, 0);
        // unused kernel code falls back to Gaussian
        add_row(3, 4, ONE_Q16, unit, zeros, 0, 0);
        add_row(3, 4, ONE_Q16, maxs, mins, 1, 0);
        // no dimensions, and more dimensions than exist
        add_row(KT_GAUSS, 0, ONE_Q16, maxs, mins, 1, ONE_Q16);
        add_row(KT_MATERN32, 0, ONE_Q16, maxs, mins, 1, ONE_Q16);
        add_row(KT_GAUSS, 7, ONE_Q16, maxs, mins, 1, 0);
        add_row(KT_MATERN52, 5, ONE_Q16, unit, zeros, 0, 0);
        // zero scale gives a factor of one
        add_row(KT_GAUSS, 1, 0, edge0, edge1, 1, ONE_Q16);
        add_row(KT_MATERN52, 1, 0, edge0, edge1, 1, ONE_Q16);
        add_row(KT_MATERN32, 1, 0, edge0, edge1, 1, ONE_Q16);
        // extreme scales
        add_row(KT_GAUSS, 4, 24'hFFFFFF, unit, zeros, 0, 0);
        add_row(KT_GAUSS, 2, 1, unit, zeros, 0, 0);
        add_row(KT_MATERN32, 1, 1, edge0, edge1, 0, 0);

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.kt != cur_kernel || row.dims != cur_dims || row.scale0 != cur_scale[0])
            begin
                drain();
                write_reg(REG_KERNEL_TYPE, SCALE_W'(row.kt));
                write_reg(REG_DIMS_IN_USE, SCALE_W'(row.dims));
                write_reg(REG_INV_SCALE_0, row.scale0);
            end
            if (row.chk && covariance(row.a, row.b) !== row.val)
            begin
                $error("kernel_value: table expected %0d predictor %0d",
                       row.val, covariance(row.a, row.b));
                fail_count++;
            end
            send_pair(row.a, row.b);
        end
        drain();

        // random phases under varied settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idle_on = (ph != 3);
            rk = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            rd = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
            if (ph < 3)
                rk = 2'(ph);
            write_reg(REG_KERNEL_TYPE, SCALE_W'(rk));
            write_reg(REG_DIMS_IN_USE, SCALE_W'(rd));
            write_reg(REG_INV_SCALE_0, pick_scale(ph == 4 ? 0 : (ph == 5 ? 1 : 2)));
            write_reg(REG_INV_SCALE_1, pick_scale(ph == 4 ? 0 : (ph == 5 ? 1 : 2)));
            write_reg(REG_INV_SCALE_2, pick_scale(ph == 4 ? 0 : (ph == 5 ? 1 : 2)));
            write_reg(REG_INV_SCALE_3, pick_scale(ph == 4 ? 0 : (ph == 5 ? 1 : 2)));
            // unknown index must leave every register alone
            write_reg(CFG_IDX_W'($urandom_range(6, 7)), SCALE_W'($urandom()));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly nearby pairs so the value stays inside its range
                span = (ph == 4) ? 10 : $urandom_range(6, 20);
                for (int k = 0; k < NUM_COORDS; k++)
                begin
                    ra[k] = pick_coord();
                    if ($urandom_range(9) < 8)
                        rb[k] = ra[k] - COORD_W'(signed'($urandom_range(0, (1 << span) - 1))
                                - (1 << (span - 1)));
                    else
                        rb[k] = pick_coord();
                end
                send_pair(ra, rb);
                if (n == PHASE_ITEMS / 2)
                begin
                    req_valid = 1'b0;
                    while (pending_values.size() != 0)
                        @(negedge clk);
                end
            end
            drain();
        end

        idle_on = 1'b0;
        drain();
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
